### design/mkt_pkg.sv
// ----------------------------------------------------------------------------
// mkt_pkg
// Shared constants, types and helpers for the MAC keyed node table.
// ----------------------------------------------------------------------------
package mkt_pkg;

    localparam int ENTRIES      = 32;
    localparam int VERSION_BITS = 32;

    localparam int MAC_W    = 48;
    localparam int VER_IN_W = 32;
    localparam int ACT_W    = 2;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // stream payload widths
    localparam int IN_TDATA_W  = 80;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 8;

    // request codes; the unused code behaves like a check
    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CHECK  = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic [MAC_W-1:0]        mac;
        logic [VERSION_BITS-1:0] version;
        logic                    given;
    } t_req;

    // search token passed cell to cell
    typedef struct packed {
        logic             active;
        logic             hit;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
    } t_token;

    // allocation write broadcast to all cells
    typedef struct packed {
        logic                    en;
        logic [IDX_W-1:0]        idx;
        logic [MAC_W-1:0]        mac;
        logic [VERSION_BITS-1:0] version;
    } t_wr;

    // input version fitted to the stored width (zero above bit 31)
    function automatic logic [VERSION_BITS-1:0] ver_fit(input logic [VER_IN_W-1:0] v);
        logic [63:0] w;
        w = {32'b0, v};
        return w[VERSION_BITS-1:0];
    endfunction

endpackage

### design/mkt_cell.sv
// ----------------------------------------------------------------------------
// mkt_cell
// One table slot: valid bit, MAC key and version. Compares the request when
// the search token passes and forwards the updated token to the next slot.
// ----------------------------------------------------------------------------
module mkt_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [mkt_pkg::IDX_W-1:0] i_index,
    input  mkt_pkg::t_req             i_req,
    input  mkt_pkg::t_wr              i_wr,
    input  mkt_pkg::t_token           i_tok,
    output mkt_pkg::t_token           o_tok
);

    logic                             r_valid;
    logic [mkt_pkg::MAC_W-1:0]        r_mac;
    logic [mkt_pkg::VERSION_BITS-1:0] r_ver;
    mkt_pkg::t_token                  r_tok;

    logic                             n_valid;
    logic [mkt_pkg::MAC_W-1:0]        n_mac;
    logic [mkt_pkg::VERSION_BITS-1:0] n_ver;
    mkt_pkg::t_token                  n_tok;
    logic                             w_hit;

    assign w_hit = i_tok.active && r_valid && (r_mac == i_req.mac);

    always_comb begin
        n_valid = r_valid;
        n_mac   = r_mac;
        n_ver   = r_ver;
        if (i_wr.en && (i_wr.idx == i_index)) begin
            n_valid = 1'b1;
            n_mac   = i_wr.mac;
            n_ver   = i_wr.version;
        end
        if (w_hit) begin
            if ((i_req.action == mkt_pkg::ACT_ADD) && i_req.given) begin
                n_ver = i_req.version;
            end
            if (i_req.action == mkt_pkg::ACT_DELETE) begin
                n_valid = 1'b0;
            end
        end

        n_tok.active     = i_tok.active;
        n_tok.hit        = i_tok.hit | w_hit;
        // free status taken before any delete in this pass
        n_tok.free_found = i_tok.free_found | (i_tok.active & ~r_valid);
        n_tok.free_idx   = i_tok.free_found ? i_tok.free_idx : i_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mac <= n_mac;
        r_ver <= n_ver;
    end

    assign o_tok = r_tok;

endmodule

### design/mac_keyed_node_table_unit.sv
// ----------------------------------------------------------------------------
// mac_keyed_node_table_unit
// Bounded table of mesh node entries keyed by a 48-bit MAC address.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel: tdata carries mac and version,
//   tuser carries the action code and the version_given flag. Each request
//   gives exactly one result on m_axis: found (MAC present before the
//   request) and status (table full on add of a new MAC).
//   The slots form a row of cells. A search token enters the first cell in the
//   cycle after the transfer and moves one cell per cycle; the result is then
//   registered in the tail register and then in the output register. One
//   request is in the table at a time: a new request is accepted only once
//   the previous result has gone into the output register.
//   Hits update or delete in place as the token passes; a new MAC is written
//   into the lowest free slot after the walk.
//   Reset (synchronous, active low) empties the table at once; no sweep.
//   If the receiver stalls, the finished result waits in the output register
//   and the next request is already accepted and searched; its result then
//   waits until the output register frees up.
// ----------------------------------------------------------------------------
module mac_keyed_node_table_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [47:0] mac, [79:48] version
    input  logic [mkt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] action, [2] version_given
    input  logic [mkt_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] found, [1] status, [7:2] zero
    output logic [mkt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state          r_state;
    mkt_pkg::t_req   r_req;
    mkt_pkg::t_token r_launch;
    mkt_pkg::t_token r_tail;
    mkt_pkg::t_wr    r_wr;
    logic            r_out_valid;
    logic            r_found;
    logic            r_status;

    mkt_pkg::t_token             w_tok [mkt_pkg::ENTRIES+1];
    logic [mkt_pkg::ENTRIES:0]   w_tok_act;
    logic                        w_is_add;
    logic                        w_out_free;

    assign w_tok[0] = r_launch;

    genvar gi;
    generate
        for (gi = 0; gi < mkt_pkg::ENTRIES; gi++) begin : g_cell
            mkt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_index (mkt_pkg::IDX_W'(gi)),
                .i_req   (r_req),
                .i_wr    (r_wr),
                .i_tok   (w_tok[gi]),
                .o_tok   (w_tok[gi+1])
            );
        end
        for (gi = 0; gi <= mkt_pkg::ENTRIES; gi++) begin : g_act
            assign w_tok_act[gi] = w_tok[gi].active;
        end
    endgenerate

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_is_add      = (r_req.action == mkt_pkg::ACT_ADD);
    assign w_out_free    = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= '0;
            r_tail      <= '0;
            r_wr        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_launch <= '0;
            r_wr.en  <= 1'b0;
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_req.action    <= s_axis_tuser[1:0];
                        r_req.given     <= s_axis_tuser[2];
                        r_req.mac       <= s_axis_tdata[47:0];
                        r_req.version   <= mkt_pkg::ver_fit(s_axis_tdata[79:48]);
                        r_launch.active <= 1'b1;
                        r_state         <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_tok[mkt_pkg::ENTRIES].active) begin
                        r_tail  <= w_tok[mkt_pkg::ENTRIES];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_found     <= r_tail.hit;
                        r_status    <= w_is_add && !r_tail.hit && !r_tail.free_found;
                        r_wr.en     <= w_is_add && !r_tail.hit && r_tail.free_found;
                        r_wr.idx    <= r_tail.free_idx;
                        r_wr.mac    <= r_req.mac;
                        r_wr.version <= r_req.given ? r_req.version : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(mkt_pkg::OUT_TDATA_W-2){1'b0}}, r_status, r_found};

    // only one request in flight
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a request is in flight");

    // at most one search token anywhere in the row
    a_single_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_act))
        else $error("more than one search token in the cell row");

    // full status only for a MAC that was absent
    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("full status reported on a hit");

    // an allocation never follows a hit or a non-add request
    a_alloc_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr.en |-> (!r_found && w_is_add && !r_status))
        else $error("allocation write without an add miss");

endmodule

### dv/mac_keyed_node_table_unit_tb.sv
// ----------------------------------------------------------------------------
// mac_keyed_node_table_unit_tb
// Self-checking bench for the MAC keyed node table. A queue of requests is
// streamed into the slave side with random source gaps and sink stalls. Each
// accepted request is applied to a shadow copy of the table, and the
// predicted found/status pair is checked against the master side in order.
// ----------------------------------------------------------------------------
module mac_keyed_node_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // unused code, acts as a check
    localparam logic [mkt_pkg::ACT_W-1:0] ACT_SPARE = 2'd3;
    localparam int POOL_SIZE   = 48;                  // more keys than slots, so the table fills
    localparam int NUM_ITEMS   = 1950;
    localparam int QUIET_TAIL  = 150;                 // last transfers run with no idling
    localparam int DRAIN_LIMIT = 4000;
    localparam longint TIMEOUT_NS = 64'd10_000_000;

    typedef struct packed {
        logic found;
        logic status;
    } t_reply;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [mkt_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;    // [47:0] mac, [79:48] version
    logic [mkt_pkg::IN_TUSER_W-1:0] s_axis_tuser = '0;    // [1:0] action, [2] version_given
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [mkt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;        // [0] found, [1] status, [7:2] zero

    mac_keyed_node_table_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // shadow table
    logic                             slot_used [mkt_pkg::ENTRIES];
    logic [mkt_pkg::MAC_W-1:0]        slot_mac  [mkt_pkg::ENTRIES];
    logic [mkt_pkg::VERSION_BITS-1:0] slot_ver  [mkt_pkg::ENTRIES];

    mkt_pkg::t_req pending_reqs[$];
    t_reply        expected_replies[$];
    logic [mkt_pkg::MAC_W-1:0] key_pool[POOL_SIZE];

    logic   req_done = 1'b0;
    int     src_gap = 0;
    int     snk_stall = 0;
    int     src_gap_pct = 0;
    int     snk_stall_pct = 0;
    longint cyc = 0;
    int     mismatches = 0;
    int     accepted_count = 0;
    mkt_pkg::t_req nxt_req;
    t_reply got_reply;
    t_reply exp_reply;

    // Applies one request to the shadow table and returns what the block
    // should answer. The lowest matching slot and the lowest free slot win.
    function automatic t_reply node_table_apply(input mkt_pkg::t_req rq);
        int     hit;
        int     spare;
        t_reply r;
        hit = -1;
        spare = -1;
        for (int i = mkt_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (slot_used[i] && slot_mac[i] == rq.mac) hit = i;
            if (!slot_used[i]) spare = i;
        end
        r.found = (hit >= 0);
        r.status = 1'b0;
        if (rq.action == mkt_pkg::ACT_ADD) begin
            if (hit >= 0) begin
                if (rq.given) slot_ver[hit] = rq.version;
            end else if (spare < 0) begin
                r.status = 1'b1;
            end else begin
                slot_used[spare] = 1'b1;
                slot_mac[spare] = rq.mac;
                slot_ver[spare] = rq.given ? rq.version : '0;
            end
        end else if (rq.action == mkt_pkg::ACT_DELETE) begin
            if (hit >= 0) slot_used[hit] = 1'b0;
        end
        return r;
    endfunction

    function automatic mkt_pkg::t_req make_req(input logic [mkt_pkg::ACT_W-1:0] act,
                                               input logic [mkt_pkg::MAC_W-1:0] mac,
                                               input logic [mkt_pkg::VERSION_BITS-1:0] ver,
                                               input logic given);
        mkt_pkg::t_req rq;
        rq.action = act;
        rq.mac = mac;
        rq.version = ver;
        rq.given = given;
        return rq;
    endfunction

    function automatic logic [mkt_pkg::MAC_W-1:0] rand_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[mkt_pkg::MAC_W-1:0];
    endfunction

    // idle intensity is redrawn whenever the low byte of the cycle counter is zero; zero gives busy stretches
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc[7:0] == 8'd0) begin
            case ($urandom_range(3))
                0: src_gap_pct <= 0;
                1: src_gap_pct <= 10;
                default: src_gap_pct <= 35;
            endcase
            case ($urandom_range(3))
                0: snk_stall_pct <= 0;
                1: snk_stall_pct <= 10;
                default: snk_stall_pct <= 35;
            endcase
        end
    end

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || req_done) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (pending_reqs.size() > QUIET_TAIL &&
                         $urandom_range(99) < src_gap_pct) begin
                src_gap <= $urandom_range(17);
                s_axis_tvalid <= 1'b0;
            end else begin
                nxt_req = pending_reqs.pop_front();
                s_axis_tdata <= {nxt_req.version, nxt_req.mac};
                s_axis_tuser <= {nxt_req.given, nxt_req.action};
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // result sink back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (snk_stall > 0) begin
            snk_stall <= snk_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (pending_reqs.size() > QUIET_TAIL &&
                     $urandom_range(99) < snk_stall_pct) begin
            snk_stall <= $urandom_range(17);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor: check results first, then predict the request taken this edge
    always @(posedge i_clk) begin
        req_done <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_reply.found = m_axis_tdata[0];
                got_reply.status = m_axis_tdata[1];
                if (expected_replies.size() == 0) begin
                    $error("result transfer with nothing expected: found=%0b status=%0b",
                           got_reply.found, got_reply.status);
                    mismatches++;
                end else begin
                    exp_reply = expected_replies.pop_front();
                    if (got_reply.found !== exp_reply.found) begin
                        $error("found: expected %0b, actual %0b",
                               exp_reply.found, got_reply.found);
                        mismatches++;
                    end
                    if (got_reply.status !== exp_reply.status) begin
                        $error("status: expected %0b, actual %0b",
                               exp_reply.status, got_reply.status);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_replies.push_back(node_table_apply(make_req(
                    s_axis_tuser[1:0], s_axis_tdata[47:0], s_axis_tdata[79:48],
                    s_axis_tuser[2])));
                accepted_count++;
            end
        end
    end

    initial begin
        int               profile;
        int               phase_left;
        int               roll;
        int               add_pct;
        int               del_pct;
        logic [mkt_pkg::ACT_W-1:0]        act;
        logic [mkt_pkg::MAC_W-1:0]        mac;
        logic [mkt_pkg::VERSION_BITS-1:0] ver;
        int               drain;
        int               total_reqs;

        for (int i = 0; i < mkt_pkg::ENTRIES; i++) begin
            slot_used[i] = 1'b0;
            slot_mac[i] = '0;
            slot_ver[i] = '0;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = rand_mac();

        // directed: key and version extremes, every action, update without version
        pending_reqs.push_back(make_req(mkt_pkg::ACT_CHECK,  '0, '0, 1'b0));
        pending_reqs.push_back(make_req(mkt_pkg::ACT_DELETE, '0, '0, 1'b0));
        pending_reqs.push_back(make_req(mkt_pkg::ACT_ADD,    '0, '0, 1'b1));
        pending_reqs.push_back(make_req(mkt_pkg::ACT_ADD,    '1, '1, 1'b1));
        pending_reqs.push_back(make_req(mkt_pkg::ACT_ADD,    '1, 32'h1234_5678, 1'b0));
        pending_reqs.push_back(make_req(mkt_pkg::ACT_ADD,    '1, 32'h8000_0001, 1'b1));
        pending_reqs.push_back(make_req(mkt_pkg::ACT_CHECK,  '1, '1, 1'b1));
        pending_reqs.push_back(make_req(ACT_SPARE,           '0, '1, 1'b1));
        pending_reqs.push_back(make_req(ACT_SPARE,           48'h0000_0000_0001, '0, 1'b0));
        pending_reqs.push_back(make_req(mkt_pkg::ACT_ADD,    48'h7FFF_FFFF_FFFF, '0, 1'b0));
        pending_reqs.push_back(make_req(mkt_pkg::ACT_CHECK,  48'hFFFF_FFFF_FFFE, '0, 1'b0));
        pending_reqs.push_back(make_req(mkt_pkg::ACT_DELETE, '0, '1, 1'b1));
        pending_reqs.push_back(make_req(mkt_pkg::ACT_DELETE, '0, '0, 1'b0));
        pending_reqs.push_back(make_req(mkt_pkg::ACT_CHECK,  '0, '0, 1'b0));
        pending_reqs.push_back(make_req(mkt_pkg::ACT_ADD,    '0, 32'hA5A5_5A5A, 1'b0));
        pending_reqs.push_back(make_req(mkt_pkg::ACT_DELETE, 48'h7FFF_FFFF_FFFF, '0, 1'b1));
        pending_reqs.push_back(make_req(mkt_pkg::ACT_ADD,    48'h7FFF_FFFF_FFFF, '1, 1'b1));

        // random: fill, drain and mixed phases over a key pool larger than the table
        phase_left = 0;
        profile = 0;
        while (pending_reqs.size() < NUM_ITEMS) begin
            if (phase_left == 0) begin
                profile = $urandom_range(2);
                phase_left = $urandom_range(60, 200);
            end
            phase_left--;
            case (profile)
                0: begin add_pct = 70; del_pct = 5; end
                1: begin add_pct = 20; del_pct = 55; end
                default: begin add_pct = 40; del_pct = 25; end
            endcase
            roll = $urandom_range(99);
            if (roll < add_pct)                act = mkt_pkg::ACT_ADD;
            else if (roll < add_pct + del_pct) act = mkt_pkg::ACT_DELETE;
            else if (roll < 95)                act = mkt_pkg::ACT_CHECK;
            else                               act = ACT_SPARE;
            roll = $urandom_range(99);
            if (roll < 85)
                mac = key_pool[$urandom_range(POOL_SIZE - 1)];
            else if (roll < 95)   // near miss: one bit off a known key
                mac = key_pool[$urandom_range(POOL_SIZE - 1)] ^ (48'd1 << $urandom_range(47));
            else
                mac = rand_mac();
            roll = $urandom_range(19);
            if (roll == 0)      ver = '0;
            else if (roll == 1) ver = '1;
            else                ver = $urandom;
            pending_reqs.push_back(make_req(act, mac, ver, 1'($urandom_range(1))));
        end
        total_reqs = pending_reqs.size();

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // counted at the monitor edge, so no race with the driver
        while (accepted_count < total_reqs) @(negedge i_clk);
        drain = 0;
        while (expected_replies.size() != 0 && drain < DRAIN_LIMIT) begin
            @(negedge i_clk);
            drain++;
        end
        repeat (mkt_pkg::ENTRIES + 8) @(negedge i_clk);

        if (expected_replies.size() != 0)
            $error("%0d expected results never arrived", expected_replies.size());
        if (mismatches == 0 && expected_replies.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule

### mac_keyed_node_table_unit.f
design/mkt_pkg.sv
design/mkt_cell.sv
design/mac_keyed_node_table_unit.sv
dv/mac_keyed_node_table_unit_tb.sv
